// ===== design/ftw_pkg.sv =====
// ----------------------------------------------------------------------------
// ftw_pkg: shared constants and types for the face-thinning warp map
// Field widths, register indexes and the fixed scale constants of the warp.
// ----------------------------------------------------------------------------
package ftw_pkg;

    // port field widths
    localparam int IN_W       = 12;   // pixel_x / pixel_y
    localparam int PT_W       = 24;   // packed landmark point
    localparam int LVL_W      = 7;    // thin_level
    localparam int OUT_W      = 19;   // source_x_fixed / source_y_fixed
    localparam int CFG_AW     = 3;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 40;

    // parameter defaults
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 5;

    // warp arithmetic
    localparam int                LEVEL_MAX_I = 100;
    localparam logic [LVL_W-1:0]  LEVEL_MAX   = LVL_W'(LEVEL_MAX_I);
    localparam int                SCALE_MUL   = 3;      // 0.15/100 = 3/2000
    localparam int                DIV_W       = 11;
    localparam logic [DIV_W-1:0]  S_DIV       = DIV_W'(2000);
    localparam int                Q_SHIFT     = 16;     // Q16 falloff
    localparam int                T_W         = 17;     // falloff 0..65536
    localparam int                S_NUM_W     = 25;     // level*3*t2
    localparam int                S_W         = 14;     // scale Q16
    localparam int                ACC_FRAC    = 24;     // Q8 offset * Q16 scale
    localparam int                OUT_MAX     = 262143;
    localparam int                OUT_MIN     = -262144;

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_NOSE  = 3'd0,
        CFG_CHIN  = 3'd1,
        CFG_LJAW  = 3'd2,
        CFG_RJAW  = 3'd3,
        CFG_LEVEL = 3'd4
    } t_cfg_idx;

endpackage

// ===== design/ftw_delay.sv =====
// ----------------------------------------------------------------------------
// ftw_delay: enabled shift line
// Carries side data alongside the arithmetic units, advancing with the pipe.
// ----------------------------------------------------------------------------
module ftw_delay import ftw_pkg::*; #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sr [D];

    // tap 0 takes the input, each later tap the one before
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[D-1];

endmodule

// ===== design/ftw_isqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// ftw_isqrt_pipe: pipelined integer square root
// Digit-by-digit floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ftw_isqrt_pipe import ftw_pkg::*; #(
    parameter int IW = 41,
    parameter int RW = (IW + 1) / 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [IW-1:0] i_val,
    output logic [RW-1:0] o_root
);

    localparam int PW = 2 * RW;

    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [PW-1:0] r_lo   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        logic [RW+1:0] w_rem_in;
        logic [RW-1:0] w_root_in;
        logic [PW-1:0] w_lo_in;
        logic [RW+3:0] w_t;
        logic [RW+3:0] w_trial;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_lo_in   = PW'(i_val);
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_lo_in   = r_lo[k-1];
        end

        // bring down two bits, try root*4+1
        assign w_t     = {w_rem_in, w_lo_in[PW-1:PW-2]};
        assign w_trial = (RW+4)'({w_root_in, 2'b01});
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (RW+2)'(w_t - w_trial) : (RW+2)'(w_t);
                r_root[k] <= (w_root_in << 1) | RW'(w_ge);
                r_lo[k]   <= w_lo_in << 2;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== design/ftw_div_pipe.sv =====
// ----------------------------------------------------------------------------
// ftw_div_pipe: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module ftw_div_pipe import ftw_pkg::*; #(
    parameter int NW = 8,
    parameter int DW = 4,
    parameter int QW = 4
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int EW = DW + QW;

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_lo_in;
        logic [QW-1:0] w_q_in;
        logic [DW:0]   w_t;
        logic          w_ge;

        if (k == 0) begin : g_first
            logic [EW-1:0] w_ext;
            assign w_ext    = EW'(i_num);
            assign w_rem_in = w_ext[EW-1:QW];
            assign w_lo_in  = w_ext[QW-1:0];
            assign w_q_in   = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_lo_in  = r_lo[k-1];
            assign w_q_in   = r_q[k-1];
            assign w_den_in = r_den[k-1];
        end

        // shift in the next dividend bit and try a subtract
        assign w_t  = {w_rem_in, w_lo_in[QW-1]};
        assign w_ge = (w_t >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? DW'(w_t - {1'b0, w_den_in}) : DW'(w_t);
                r_lo[k]  <= w_lo_in << 1;
                r_q[k]   <= (w_q_in << 1) | QW'(w_ge);
                r_den[k] <= w_den_in;
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

// ===== design/face_thinning_warp_map_top.sv =====
// ----------------------------------------------------------------------------
// face_thinning_warp_map_top: face-thinning warp coordinate map
// Maps each destination pixel to the source coordinate to sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s side): one word per pixel, pixel_x and pixel_y.
//   Output stream (m side): one word per input word, in order, carrying the
//   source coordinate in 1/2^FRAC_BITS pixel units and the inside flag.
//   Configuration: landmarks and thin_level through the write port; write
//   only while no pixel is in flight.
//   Throughput: one word per cycle unless the output stalls. Each word
//   passes the square-root pipes (root width RW = COORD_BITS + 9; radius
//   and distance run side by side), then the falloff divider and the
//   scale divider in series.
//   Reset clears all valid bits and the configuration registers (identity
//   map with nose = chin, no pixel inside).
//   Stall: when the output word is held and not taken, the whole pipe
//   freezes and o_s_tready drops; nothing is lost or repeated. Empty
//   pipe slots do not block input.
// ----------------------------------------------------------------------------
module face_thinning_warp_map_top import ftw_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // pixel_x [11:0], pixel_y [23:12]
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // source_x_fixed [18:0], source_y_fixed [37:19], zero fill [39:38]
    output logic [M_DATA_W-1:0] o_m_tdata,
    // inside_region [0]
    output logic                o_m_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [PT_W-1:0]     i_cfg_wdata
);

    localparam int C      = COORD_BITS;
    localparam int DFW    = C + 1;
    localparam int PRW    = 2 * C + 2;
    localparam int R2W    = 2 * C + 1;
    localparam int CRW    = 2 * C + 3;
    localparam int CMW    = 2 * C + 1;
    localparam int SQ_IW  = R2W + Q_SHIFT;
    localparam int RW     = (SQ_IW + 1) / 2;
    localparam int PYW    = C + CMW;
    localparam int OXN_W  = PYW + 8;
    localparam int OX_QW  = C + 9;
    localparam int T_NW   = RW + Q_SHIFT;
    localparam int SH     = ACC_FRAC - FRAC_BITS;
    localparam int PROD_W = OX_QW + S_W + 1;
    localparam int DM_W   = PROD_W - SH;
    localparam int T_S    = RW + T_W + S_W + 3;
    localparam int T_OX   = 2 + OX_QW;
    localparam int D_OX   = T_S - T_OX;
    localparam int D_SB   = T_S - 1;
    localparam int NV     = T_S + 5;
    localparam int SB_W   = 2 * C + 3;
    localparam int SUM_W  = (C + FRAC_BITS + 2 > OUT_W + 1) ? C + FRAC_BITS + 2 : OUT_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

    // configuration registers
    logic [PT_W-1:0]  r_nose, r_chin, r_ljaw, r_rjaw;
    logic [LVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nose  <= '0;
            r_chin  <= '0;
            r_ljaw  <= '0;
            r_rjaw  <= '0;
            r_level <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_NOSE:  r_nose  <= i_cfg_wdata;
                CFG_CHIN:  r_chin  <= i_cfg_wdata;
                CFG_LJAW:  r_ljaw  <= i_cfg_wdata;
                CFG_RJAW:  r_rjaw  <= i_cfg_wdata;
                CFG_LEVEL: r_level <= LVL_W'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // pipe enable and valid chain
    logic          w_en, w_acc;
    logic [NV-1:0] r_v;

    assign w_en       = !r_v[NV-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign w_acc      = i_s_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NV-2:0], w_acc};
        end
    end

    // stage 1: coordinate differences
    logic [C-1:0]          w_x, w_y, w_nx, w_ny, w_cx, w_cy, w_jx, w_jy;
    logic [PT_W-1:0]       w_jaw;
    logic signed [DFW-1:0] r1_ax, r1_ay, r1_jx, r1_jy, r1_vx, r1_vy;
    logic [C-1:0]          r1_x, r1_y;

    assign w_x   = C'(i_s_tdata[IN_W-1:0]);
    assign w_y   = C'(i_s_tdata[2*IN_W-1:IN_W]);
    assign w_nx  = C'(r_nose);
    assign w_ny  = C'(r_nose >> C);
    assign w_cx  = C'(r_chin);
    assign w_cy  = C'(r_chin >> C);
    assign w_jaw = (w_x < w_nx) ? r_ljaw : r_rjaw;
    assign w_jx  = C'(w_jaw);
    assign w_jy  = C'(w_jaw >> C);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax <= $signed({1'b0, w_cx}) - $signed({1'b0, w_nx});
            r1_ay <= $signed({1'b0, w_cy}) - $signed({1'b0, w_ny});
            r1_jx <= $signed({1'b0, w_x}) - $signed({1'b0, w_jx});
            r1_jy <= $signed({1'b0, w_y}) - $signed({1'b0, w_jy});
            r1_vx <= $signed({1'b0, w_x}) - $signed({1'b0, w_nx});
            r1_vy <= $signed({1'b0, w_y}) - $signed({1'b0, w_ny});
            r1_x  <= w_x;
            r1_y  <= w_y;
        end
    end

    // stage 2: products
    logic signed [PRW-1:0] r2_axax, r2_ayay, r2_jxjx, r2_jyjy, r2_vxay, r2_vyax;
    logic signed [DFW-1:0] r2_ax, r2_ay;
    logic [C-1:0]          r2_x, r2_y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_axax <= PRW'(r1_ax) * PRW'(r1_ax);
            r2_ayay <= PRW'(r1_ay) * PRW'(r1_ay);
            r2_jxjx <= PRW'(r1_jx) * PRW'(r1_jx);
            r2_jyjy <= PRW'(r1_jy) * PRW'(r1_jy);
            r2_vxay <= PRW'(r1_vx) * PRW'(r1_ay);
            r2_vyax <= PRW'(r1_vy) * PRW'(r1_ax);
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
        end
    end

    // stage 3: squared radius, squared distance, cross product
    logic [R2W-1:0]        w_r2, w_d2, r3_r2, r3_d2;
    logic signed [CRW-1:0] r3_cross;
    logic signed [DFW-1:0] r3_ax, r3_ay;
    logic [C-1:0]          r3_x, r3_y;
    logic                  r3_in;

    assign w_r2 = R2W'($unsigned(r2_axax + r2_ayay));
    assign w_d2 = R2W'($unsigned(r2_jxjx + r2_jyjy));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_r2    <= w_r2;
            r3_d2    <= w_d2;
            r3_in    <= (w_d2 < w_r2);
            r3_cross <= CRW'(r2_vxay) - CRW'(r2_vyax);
            r3_ax    <= r2_ax;
            r3_ay    <= r2_ay;
            r3_x     <= r2_x;
            r3_y     <= r2_y;
        end
    end

    // stage 4: magnitudes and displacement signs
    logic [CMW-1:0] r4_cm;
    logic [C-1:0]   r4_axm, r4_aym, r4_x, r4_y;
    logic [R2W-1:0] r4_r2;
    logic           r4_xneg, r4_yneg, r4_in;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_cm   <= CMW'(r3_cross < 0 ? -r3_cross : r3_cross);
            r4_axm  <= C'(r3_ax < 0 ? -r3_ax : r3_ax);
            r4_aym  <= C'(r3_ay < 0 ? -r3_ay : r3_ay);
            r4_xneg <= (r3_ay < 0) != (r3_cross < 0);
            r4_yneg <= !((r3_ax < 0) != (r3_cross < 0));
            r4_r2   <= r3_r2;
            r4_in   <= r3_in;
            r4_x    <= r3_x;
            r4_y    <= r3_y;
        end
    end

    // stage 5: offset numerators
    logic [PYW-1:0] r5_pay, r5_pax;
    logic [R2W-1:0] r5_r2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_pay <= PYW'(r4_aym) * PYW'(r4_cm);
            r5_pax <= PYW'(r4_axm) * PYW'(r4_cm);
            r5_r2  <= r4_r2;
        end
    end

    // perpendicular offsets, Q8
    logic [OX_QW-1:0] w_ox, w_oy, w_ox_d, w_oy_d;

    ftw_div_pipe #(.NW(OXN_W), .DW(R2W), .QW(OX_QW)) u_div_ox (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r5_pay, 8'b0}),
        .i_den (r5_r2),
        .o_quo (w_ox)
    );

    ftw_div_pipe #(.NW(OXN_W), .DW(R2W), .QW(OX_QW)) u_div_oy (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r5_pax, 8'b0}),
        .i_den (r5_r2),
        .o_quo (w_oy)
    );

    ftw_delay #(.W(2 * OX_QW), .D(D_OX)) u_dly_off (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_oy, w_ox}),
        .o_q   ({w_oy_d, w_ox_d})
    );

    // side data: coordinates, inside flag, signs
    logic [SB_W-1:0] w_sb_d;
    logic [C-1:0]    w_sbx, w_sby;
    logic            w_sbin, w_sbxn, w_sbyn;

    ftw_delay #(.W(SB_W), .D(D_SB)) u_dly_sb (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r4_yneg, r4_xneg, r4_in, r4_y, r4_x}),
        .o_q   (w_sb_d)
    );

    assign {w_sbyn, w_sbxn, w_sbin, w_sby, w_sbx} = w_sb_d;

    // radius and distance in Q8
    logic [RW-1:0] w_rq, w_dq, w_rqc, w_dqc;

    ftw_isqrt_pipe #(.IW(SQ_IW)) u_sqrt_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({r3_r2, 16'b0}),
        .o_root (w_rq)
    );

    ftw_isqrt_pipe #(.IW(SQ_IW)) u_sqrt_d (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({r3_d2, 16'b0}),
        .o_root (w_dq)
    );

    // falloff operands, guarded against zero radius
    logic [T_NW-1:0] r_t_num;
    logic [RW-1:0]   r_t_den;

    assign w_rqc = (w_rq == '0) ? RW'(1) : w_rq;
    assign w_dqc = (w_dq > w_rqc) ? w_rqc : w_dq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_num <= {w_rqc - w_dqc, 16'b0};
            r_t_den <= w_rqc;
        end
    end

    logic [T_W-1:0] w_t;

    ftw_div_pipe #(.NW(T_NW), .DW(RW), .QW(T_W)) u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_t_num),
        .i_den (r_t_den),
        .o_quo (w_t)
    );

    // falloff squared, then level scaling
    logic [2*T_W-1:0]   w_tt;
    logic [T_W-1:0]     r_t2;
    logic [LVL_W-1:0]   w_lvl;
    logic [LVL_W+1:0]   w_l3;
    logic [S_NUM_W-1:0] r_sn;

    assign w_tt  = (2 * T_W)'(w_t) * (2 * T_W)'(w_t);
    assign w_lvl = (r_level > LEVEL_MAX) ? LEVEL_MAX : r_level;
    assign w_l3  = (LVL_W + 2)'(w_lvl) * (LVL_W + 2)'(SCALE_MUL);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t2 <= T_W'(w_tt >> Q_SHIFT);
            r_sn <= S_NUM_W'(w_l3) * S_NUM_W'(r_t2);
        end
    end

    logic [S_W-1:0] w_s;

    ftw_div_pipe #(.NW(S_NUM_W), .DW(DIV_W), .QW(S_W)) u_div_s (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_sn),
        .i_den (S_DIV),
        .o_quo (w_s)
    );

    // displacement, rounded half away from zero to the output fraction
    logic [PROD_W-1:0] w_px, w_py;
    logic [DM_W-1:0]   r_dmx, r_dmy;
    logic [C-1:0]      r_rx, r_ry;
    logic              r_rin, r_rxn, r_ryn;

    assign w_px = PROD_W'(w_ox_d) * PROD_W'(w_s) + (PROD_W'(1) << (SH - 1));
    assign w_py = PROD_W'(w_oy_d) * PROD_W'(w_s) + (PROD_W'(1) << (SH - 1));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dmx <= w_sbin ? DM_W'(w_px >> SH) : '0;
            r_dmy <= w_sbin ? DM_W'(w_py >> SH) : '0;
            r_rxn <= w_sbin && w_sbxn;
            r_ryn <= w_sbin && w_sbyn;
            r_rin <= w_sbin;
            r_rx  <= w_sbx;
            r_ry  <= w_sby;
        end
    end

    // output stage: apply displacement and saturate
    logic signed [SUM_W-1:0] w_bx, w_by, w_sx, w_sy;
    logic [OUT_W-1:0]        r_ox, r_oy;
    logic                    r_oin;

    assign w_bx = $signed(SUM_W'(r_rx) << FRAC_BITS);
    assign w_by = $signed(SUM_W'(r_ry) << FRAC_BITS);
    assign w_sx = r_rxn ? w_bx - $signed(SUM_W'(r_dmx)) : w_bx + $signed(SUM_W'(r_dmx));
    assign w_sy = r_ryn ? w_by - $signed(SUM_W'(r_dmy)) : w_by + $signed(SUM_W'(r_dmy));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ox  <= (w_sx > SAT_HI) ? OUT_W'(SAT_HI) :
                     (w_sx < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(w_sx);
            r_oy  <= (w_sy > SAT_HI) ? OUT_W'(SAT_HI) :
                     (w_sy < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(w_sy);
            r_oin <= r_rin;
        end
    end

    assign o_m_tdata  = M_DATA_W'({r_oy, r_ox});
    assign o_m_tuser  = r_oin;
    assign o_m_tvalid = r_v[NV-1];

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output word valid right after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v))
        else $error("valid chain moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v[0])
        else $error("accepted word missing from first stage");

endmodule
